/* rtl/core/cccv_pkg.sv */
// Package for the CC/CV charge command controller.
// Holds channel payload types, register indexes, code constants and sequencer types.
// No dependencies.
package cccv_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MV_W   = 13;
    localparam int MA_W   = 16;
    localparam int TEMP_W = 12;
    localparam int DV_W   = 14;
    localparam int SEQ_W  = 8;

    // Taper division: charger_max_ma times a millivolt difference, over a millivolt span.
    localparam int NUM_W = MA_W + MV_W;
    localparam int DEN_W = MV_W;
    localparam int QUO_W = MA_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_CELL_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPER_BEGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_OVERVOLT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGER_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TERMINATION    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_TEMP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PACK_TARGET    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEQ_LAG    = 3'd7;

    localparam logic [MV_W-1:0]          RST_CELL_TARGET   = 13'd4180;
    localparam logic [MV_W-1:0]          RST_TAPER_BEGIN   = 13'd4080;
    localparam logic [MV_W-1:0]          RST_HARD_OVERVOLT = 13'd4200;
    localparam logic [MA_W-1:0]          RST_CHARGER_MAX   = 16'd10000;
    localparam logic [MA_W-1:0]          RST_TERMINATION   = 16'd500;
    localparam logic signed [TEMP_W-1:0] RST_CUTOFF_TEMP   = 12'sd550;
    localparam logic [DV_W-1:0]          RST_PACK_TARGET   = 14'd5434;
    localparam logic [SEQ_W-1:0]         RST_MAX_SEQ_LAG   = 8'd3;
    localparam logic [SEQ_W-1:0]         RST_SEQUENCE      = 8'd4;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_CC    = 2'd1;
    localparam logic [1:0] MODE_CV    = 2'd2;

    localparam logic [1:0] PLUG_UNPLUGGED = 2'd0;
    localparam logic [1:0] PLUG_PLUGGED   = 2'd1;
    localparam logic [1:0] PLUG_READY     = 2'd2;

    typedef struct packed {
        logic [MV_W-1:0]          max_cell_mv;
        logic signed [TEMP_W-1:0] max_temp_dc;
        logic [MA_W-1:0]          measured_current_ma;
        logic [7:0]               charger_fault_bits;
        logic [1:0]               charger_mode;
        logic [1:0]               plug_status;
        logic [SEQ_W-1:0]         sequence_echo;
        logic                     contactor_charging;
        logic                     pack_disconnected;
        logic                     pack_overtemp;
        logic                     shutdown_loop_closed;
    } cccv_in_t;

    typedef struct packed {
        logic [DV_W-1:0]  target_voltage_dv;
        logic [MA_W-1:0]  current_limit_ma;
        logic             enable_flag;
        logic             hard_stop_flag;
        logic [SEQ_W-1:0] command_sequence;
        logic             done_status;
        logic             link_ok;
    } cccv_out_t;

    typedef enum logic [1:0] {
        LIM_ZERO,
        LIM_FULL,
        LIM_TAPER
    } lim_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/cccv_if.sv */
// Channel interfaces for the CC/CV charge command controller.
// Depends on cccv_pkg for payload types and widths.
interface cccv_in_if;
    import cccv_pkg::*;
    logic     valid;
    logic     ready;
    cccv_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cccv_out_if;
    import cccv_pkg::*;
    logic      valid;
    logic      ready;
    cccv_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cccv_cfg_if;
    import cccv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/cccv_charge_command_controller.sv */
// Top level of the CC/CV charge command controller: configuration registers,
// safety and enable decisions, sequencer, taper multiply and output register.
// Depends on cccv_pkg, the channel interfaces in cccv_if and cccv_taper_div.

// One status transaction yields one command transaction. The hard stop, enable, done-latch
// and watchdog decisions are made at the edge that accepts the status, and the sequence
// counter and done latch advance there. When the cell voltage lies strictly inside the taper
// band of an enabled, not-too-hot step, the current limit needs a 16 by 13 bit multiply
// and a 29-step restoring division on a shared subtractor, so such a status passes through
// the multiply, start, divide and load states before the block takes the next one; every
// other status goes straight to the load state. The block takes no status while one is in
// work. The command sits in an output register, so the next status is accepted while the
// previous command still waits to be taken; a status finishing while that register is still
// full waits in the load state until the command is taken. Configuration writes are taken in
// every cycle and must only be made while the block is idle.
module cccv_charge_command_controller (
    input  logic        clk,
    input  logic        rst_n,
    cccv_cfg_if.sink    cfg,
    cccv_in_if.sink     status,
    cccv_out_if.source  command
);
    import cccv_pkg::*;

    // Configuration registers.
    logic [MV_W-1:0]          cell_target_reg;
    logic [MV_W-1:0]          taper_begin_reg;
    logic [MV_W-1:0]          hard_overvolt_reg;
    logic [MA_W-1:0]          charger_max_reg;
    logic [MA_W-1:0]          termination_reg;
    logic signed [TEMP_W-1:0] cutoff_temp_reg;
    logic [DV_W-1:0]          pack_target_reg;
    logic [SEQ_W-1:0]         max_seq_lag_reg;

    // Block state.
    logic [SEQ_W-1:0] seq_reg;
    logic             done_latch_reg;
    state_t           state_reg;
    state_t           state_next;

    // Per-transaction decision registers.
    lim_sel_t         lim_sel_reg;
    logic             enable_reg;
    logic             hard_reg;
    logic             link_reg;
    logic             done_out_reg;
    logic [MV_W-1:0]  diff_reg;
    logic [NUM_W-1:0] product_reg;

    cccv_out_t out_data_reg;
    logic      out_valid_reg;

    logic in_fire;
    logic out_free;
    logic div_start;
    logic load_out;

    logic [QUO_W-1:0] quotient;
    div_stat_t        div_stat;

    logic             plugged;
    logic             plug_ready;
    logic             link;
    logic             latch_kept;
    logic             hard;
    logic             go;
    logic             term;
    logic             enable;
    logic             done_next;
    lim_sel_t         lim_sel;
    logic [SEQ_W-1:0] lag;
    logic [MA_W-1:0]  limit;

    cccv_in_t s;

    assign s         = status.payload;
    assign in_fire   = status.valid && status.ready;
    assign out_free  = !out_valid_reg || command.ready;
    assign cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_target_reg   <= RST_CELL_TARGET;
            taper_begin_reg   <= RST_TAPER_BEGIN;
            hard_overvolt_reg <= RST_HARD_OVERVOLT;
            charger_max_reg   <= RST_CHARGER_MAX;
            termination_reg   <= RST_TERMINATION;
            cutoff_temp_reg   <= RST_CUTOFF_TEMP;
            pack_target_reg   <= RST_PACK_TARGET;
            max_seq_lag_reg   <= RST_MAX_SEQ_LAG;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_CELL_TARGET:   cell_target_reg   <= cfg.data[MV_W-1:0];
                REG_TAPER_BEGIN:   taper_begin_reg   <= cfg.data[MV_W-1:0];
                REG_HARD_OVERVOLT: hard_overvolt_reg <= cfg.data[MV_W-1:0];
                REG_CHARGER_MAX:   charger_max_reg   <= cfg.data[MA_W-1:0];
                REG_TERMINATION:   termination_reg   <= cfg.data[MA_W-1:0];
                REG_CUTOFF_TEMP:   cutoff_temp_reg   <= signed'(cfg.data[TEMP_W-1:0]);
                REG_PACK_TARGET:   pack_target_reg   <= cfg.data[DV_W-1:0];
                REG_MAX_SEQ_LAG:   max_seq_lag_reg   <= cfg.data[SEQ_W-1:0];
                default:           ;
            endcase
        end
    end

    // Decisions taken on the status at acceptance.
    always_comb
    begin
        plugged    = (s.plug_status == PLUG_PLUGGED) || (s.plug_status == PLUG_READY);
        plug_ready = (s.plug_status == PLUG_READY);
        lag        = seq_reg - s.sequence_echo;
        link       = (lag <= max_seq_lag_reg);
        latch_kept = plugged && done_latch_reg;
        hard       = s.pack_disconnected || s.pack_overtemp ||
                     (s.max_cell_mv > hard_overvolt_reg) || !s.shutdown_loop_closed ||
                     (s.charger_fault_bits != 8'd0);
        go         = s.contactor_charging && !hard && plug_ready && link && !latch_kept;
        term       = (s.max_cell_mv >= cell_target_reg) &&
                     (s.measured_current_ma < termination_reg) &&
                     ((s.charger_mode == MODE_CC) || (s.charger_mode == MODE_CV));
        enable     = go && !term;
        done_next  = (go && term) || latch_kept;

        // The taper band is only entered when it is strictly between start and target,
        // which also keeps the divisor nonzero.
        if (!enable || (s.max_temp_dc >= cutoff_temp_reg))
            lim_sel = LIM_ZERO;
        else if (s.max_cell_mv <= taper_begin_reg)
            lim_sel = LIM_FULL;
        else if (s.max_cell_mv >= cell_target_reg)
            lim_sel = LIM_ZERO;
        else
            lim_sel = LIM_TAPER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= RST_SEQUENCE;
            done_latch_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            seq_reg        <= seq_reg + 1'b1;
            done_latch_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lim_sel_reg  <= lim_sel;
            enable_reg   <= enable;
            hard_reg     <= hard;
            link_reg     <= link;
            done_out_reg <= done_next;
            diff_reg     <= cell_target_reg - s.max_cell_mv;
        end
        if (state_reg == ST_MUL)
            product_reg <= {{MV_W{1'b0}}, charger_max_reg} * {{MA_W{1'b0}}, diff_reg};
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.valid)
                    state_next = (lim_sel == LIM_TAPER) ? ST_MUL : ST_LOAD;
            end
            ST_MUL:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        status.ready = 1'b0;
        div_start    = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:  status.ready = 1'b1;
            ST_START: div_start    = 1'b1;
            ST_LOAD:  load_out     = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    cccv_taper_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (product_reg),
        .den      (cell_target_reg - taper_begin_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        case (lim_sel_reg)
            LIM_FULL:  limit = charger_max_reg;
            LIM_TAPER: limit = quotient;
            default:   limit = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (command.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.target_voltage_dv <= pack_target_reg;
            out_data_reg.current_limit_ma  <= limit;
            out_data_reg.enable_flag       <= enable_reg;
            out_data_reg.hard_stop_flag    <= hard_reg;
            out_data_reg.command_sequence  <= seq_reg;
            out_data_reg.done_status       <= done_out_reg;
            out_data_reg.link_ok           <= link_reg;
        end
    end

    assign command.valid   = out_valid_reg;
    assign command.payload = out_data_reg;

endmodule

/* rtl/core/cccv_taper_div.sv */
// Restoring serial divider for the current taper ratio, one quotient bit per cycle.
// Depends on cccv_pkg for operand widths and the status struct.
module cccv_taper_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cccv_pkg::NUM_W-1:0]  num,
    input  logic [cccv_pkg::DEN_W-1:0]  den,
    output logic [cccv_pkg::QUO_W-1:0]  quotient,
    output cccv_pkg::div_stat_t         stat
);
    import cccv_pkg::*;

    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    // The remainder stays below the divisor, so the shifted trial fits one extra bit.
    always_comb
    begin
        trial = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg[QUO_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/core/cccv_checker.sv */
// Port-level checker for the CC/CV charge command controller, with its bind.
// Depends on cccv_pkg for widths; binds to cccv_charge_command_controller.
module cccv_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [cccv_pkg::MA_W-1:0]   limit_ma,
    input  logic                        enable_flag,
    input  logic                        hard_stop_flag,
    input  logic                        done_status,
    input  logic [cccv_pkg::SEQ_W-1:0]  command_sequence
);
    import cccv_pkg::*;

    // A held command keeps its sequence number until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_sequence))
    else $error("command changed while stalled");

    // The block works on one status at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("status taken while another is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hard_stop_flag |-> !enable_flag && (limit_ma == '0))
    else $error("hard stop with output enabled or nonzero limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !enable_flag |-> (limit_ma == '0))
    else $error("nonzero current limit while disabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_status |-> !enable_flag)
    else $error("charger enabled with charge done");

endmodule

bind cccv_charge_command_controller cccv_checker u_cccv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (status.valid),
    .in_ready         (status.ready),
    .out_valid        (command.valid),
    .out_ready        (command.ready),
    .limit_ma         (command.payload.current_limit_ma),
    .enable_flag      (command.payload.enable_flag),
    .hard_stop_flag   (command.payload.hard_stop_flag),
    .done_status      (command.payload.done_status),
    .command_sequence (command.payload.command_sequence)
);

/* verif/cccv_command_checker.sv */
// Scoreboard for the CC/CV charge command controller: follows register writes,
// predicts one command per accepted status and compares it with the block's output.
// Depends on cccv_pkg and the channel interfaces in cccv_if.
module cccv_command_checker (
    input  logic clk,
    input  logic rst_n,
    cccv_cfg_if  cfg,
    cccv_in_if   status,
    cccv_out_if  command,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import cccv_pkg::*;

    logic [MV_W-1:0]          cell_target;
    logic [MV_W-1:0]          taper_begin;
    logic [MV_W-1:0]          hard_overvolt;
    logic [MA_W-1:0]          charger_max;
    logic [MA_W-1:0]          termination;
    logic signed [TEMP_W-1:0] cutoff_temp;
    logic [DV_W-1:0]          pack_target;
    logic [SEQ_W-1:0]         max_lag;

    logic [SEQ_W-1:0] seq_count;
    logic             done_latched;

    cccv_out_t expected_cmds[$];
    int        fail_count = 0;

    assign errors = fail_count;

    function automatic logic [MA_W-1:0] taper_current(input logic [MV_W-1:0] volt_mv);
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        if (volt_mv <= taper_begin)
            return charger_max;
        if (volt_mv >= cell_target)
            return '0;
        num = NUM_W'(charger_max) * NUM_W'(cell_target - volt_mv);
        quo = num / NUM_W'(cell_target - taper_begin);
        return quo[MA_W-1:0];
    endfunction

    // Advances the sequence counter and the done latch as the block does.
    function automatic cccv_out_t predict_command(input cccv_in_t s);
        cccv_out_t        c;
        logic [SEQ_W-1:0] lag;
        logic             plugged;
        logic             link;
        logic             hard;
        plugged = (s.plug_status == PLUG_PLUGGED) || (s.plug_status == PLUG_READY);
        lag     = seq_count - s.sequence_echo;
        link    = (lag <= max_lag);
        if (!plugged)
            done_latched = 1'b0;
        hard = s.pack_disconnected || s.pack_overtemp || (s.max_cell_mv > hard_overvolt) ||
               !s.shutdown_loop_closed || (s.charger_fault_bits != 8'd0);
        c = '0;
        if (s.contactor_charging && !hard && (s.plug_status == PLUG_READY) && link &&
            !done_latched)
        begin
            c.enable_flag = 1'b1;
            if ($signed(s.max_temp_dc) >= $signed(cutoff_temp))
                c.current_limit_ma = '0;
            else
                c.current_limit_ma = taper_current(s.max_cell_mv);
            if ((s.max_cell_mv >= cell_target) && (s.measured_current_ma < termination) &&
                ((s.charger_mode == MODE_CC) || (s.charger_mode == MODE_CV)))
            begin
                done_latched       = 1'b1;
                c.enable_flag      = 1'b0;
                c.current_limit_ma = '0;
            end
        end
        seq_count           = seq_count + 1'b1;
        c.target_voltage_dv = pack_target;
        c.hard_stop_flag    = hard;
        c.command_sequence  = seq_count;
        c.done_status       = done_latched;
        c.link_ok           = link;
        return c;
    endfunction

    always @(posedge clk)
    begin
        cccv_out_t want;
        cccv_out_t got;
        if (!rst_n)
        begin
            cell_target   = RST_CELL_TARGET;
            taper_begin   = RST_TAPER_BEGIN;
            hard_overvolt = RST_HARD_OVERVOLT;
            charger_max   = RST_CHARGER_MAX;
            termination   = RST_TERMINATION;
            cutoff_temp   = RST_CUTOFF_TEMP;
            pack_target   = RST_PACK_TARGET;
            max_lag       = RST_MAX_SEQ_LAG;
            seq_count     = RST_SEQUENCE;
            done_latched  = 1'b0;
            expected_cmds.delete();
        end
        else
        begin
            // Commands are checked before this edge's status is predicted, so a command
            // can never be matched against an expectation raised at the same edge.
            if (command.valid && command.ready)
            begin
                got = command.payload;
                if (expected_cmds.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected command seq=%0d limit=%0d",
                                 got.command_sequence, got.current_limit_ma);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"ERROR: command mismatch, expected dv=%0d ma=%0d en=%b ",
                                      "hs=%b seq=%0d done=%b link=%b, got dv=%0d ma=%0d en=%b ",
                                      "hs=%b seq=%0d done=%b link=%b"},
                                     want.target_voltage_dv, want.current_limit_ma,
                                     want.enable_flag, want.hard_stop_flag,
                                     want.command_sequence, want.done_status, want.link_ok,
                                     got.target_voltage_dv, got.current_limit_ma,
                                     got.enable_flag, got.hard_stop_flag,
                                     got.command_sequence, got.done_status, got.link_ok);
                    end
                end
            end
            if (status.valid && status.ready)
                expected_cmds.push_back(predict_command(status.payload));
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CELL_TARGET:   cell_target   = cfg.data[MV_W-1:0];
                    REG_TAPER_BEGIN:   taper_begin   = cfg.data[MV_W-1:0];
                    REG_HARD_OVERVOLT: hard_overvolt = cfg.data[MV_W-1:0];
                    REG_CHARGER_MAX:   charger_max   = cfg.data[MA_W-1:0];
                    REG_TERMINATION:   termination   = cfg.data[MA_W-1:0];
                    REG_CUTOFF_TEMP:   cutoff_temp   = cfg.data[TEMP_W-1:0];
                    REG_PACK_TARGET:   pack_target   = cfg.data[DV_W-1:0];
                    REG_MAX_SEQ_LAG:   max_lag       = cfg.data[SEQ_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding <= expected_cmds.size();
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the CC/CV charge command controller: clock, reset, register
// settings, status stimulus and command back-pressure, final verdict.
// Depends on cccv_pkg, cccv_if, the block itself and cccv_command_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cccv_pkg::*;

    localparam logic [1:0] MODE_OTHER = 2'd3;
    localparam logic [1:0] PLUG_OTHER = 2'd3;
    localparam int         SETTINGS_RUN = 8;
    localparam int         ITEMS_PER_SETTING = 205;
    localparam int         DRAIN_CYCLES = 40;

    typedef logic [CFG_DATA_W-1:0] reg_set_t [8];

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   sent = 0;
    int   received = 0;
    logic steady_src = 1'b0;
    logic steady_sink = 1'b0;

    // Copy of the active register values, used only to aim the stimulus.
    int aim_target = 4180;
    int aim_taper = 4080;
    int aim_term = 500;
    int aim_cut = 550;
    int aim_lag = 3;

    cccv_cfg_if cfg_ch ();
    cccv_in_if  status_ch ();
    cccv_out_if command_ch ();

    cccv_charge_command_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .status  (status_ch),
        .command (command_ch)
    );

    cccv_command_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .status      (status_ch),
        .command     (command_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d commands still expected", outstanding);
        $display("Test completed with failures");
        $finish;
    end

    function automatic cccv_in_t nominal_status(input logic [MV_W-1:0] cell_mv);
        cccv_in_t s;
        s = '0;
        s.max_cell_mv          = cell_mv;
        s.max_temp_dc          = 12'sd250;
        s.measured_current_ma  = 16'd5000;
        s.charger_mode         = MODE_CC;
        s.plug_status          = PLUG_READY;
        s.sequence_echo        = RST_SEQUENCE + SEQ_W'(sent);
        s.contactor_charging   = 1'b1;
        s.shutdown_loop_closed = 1'b1;
        return s;
    endfunction

    // Mostly well-formed charging ticks with random content; the rest is raw noise.
    function automatic cccv_in_t random_status();
        cccv_in_t         s;
        int               r;
        int               cell_mv;
        int               t;
        logic [SEQ_W-1:0] seq_now;
        seq_now = RST_SEQUENCE + SEQ_W'(sent);
        if ($urandom_range(0, 99) < 20)
        begin
            s.max_cell_mv          = MV_W'($urandom);
            s.max_temp_dc          = TEMP_W'($urandom);
            s.measured_current_ma  = MA_W'($urandom);
            s.charger_fault_bits   = 8'($urandom);
            s.charger_mode         = 2'($urandom);
            s.plug_status          = 2'($urandom);
            s.sequence_echo        = SEQ_W'($urandom);
            s.contactor_charging   = 1'($urandom);
            s.pack_disconnected    = 1'($urandom);
            s.pack_overtemp        = 1'($urandom);
            s.shutdown_loop_closed = 1'($urandom);
            return s;
        end
        s.contactor_charging   = ($urandom_range(0, 19) != 0);
        s.pack_disconnected    = ($urandom_range(0, 29) == 0);
        s.pack_overtemp        = ($urandom_range(0, 29) == 0);
        s.shutdown_loop_closed = ($urandom_range(0, 29) != 0);
        s.charger_fault_bits   = ($urandom_range(0, 29) == 0) ? 8'(1 << $urandom_range(0, 7))
                                                              : 8'd0;
        r = $urandom_range(0, 99);
        if (r < 92)
            s.plug_status = PLUG_READY;
        else if (r < 95)
            s.plug_status = PLUG_PLUGGED;
        else if (r < 98)
            s.plug_status = PLUG_UNPLUGGED;
        else
            s.plug_status = PLUG_OTHER;
        r = $urandom_range(0, 99);
        if (r < 45)
            s.charger_mode = MODE_CC;
        else if (r < 90)
            s.charger_mode = MODE_CV;
        else
            s.charger_mode = 2'($urandom);
        if ($urandom_range(0, 19) == 0)
            s.sequence_echo = seq_now - SEQ_W'(aim_lag + 1 + int'($urandom_range(0, 3)));
        else
            s.sequence_echo = seq_now - SEQ_W'($urandom_range(0, aim_lag));
        r = $urandom_range(0, 99);
        if (r < 40 && aim_target > aim_taper)
            cell_mv = $urandom_range(aim_taper, aim_target);
        else if (r < 60)
            cell_mv = aim_target + int'($urandom_range(0, 20));
        else if (r < 65)
            cell_mv = $urandom;
        else
            cell_mv = $urandom_range(0, aim_taper);
        s.max_cell_mv = MV_W'(cell_mv);
        s.measured_current_ma = ($urandom_range(0, 99) < 40) ? MA_W'($urandom_range(0, aim_term))
                                                             : MA_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            t = aim_cut + int'($urandom_range(0, 4)) - 2;
        else if (r < 15 || aim_cut <= -400)
            t = $urandom;
        else
            t = -400 + int'($urandom_range(0, aim_cut + 399));
        s.max_temp_dc = TEMP_W'(t);
        return s;
    endfunction

    function automatic reg_set_t setting_for(input int p);
        reg_set_t v;
        int       target;
        case (p)
            0: v = '{16'd4180, 16'd4080, 16'd4200, 16'd10000, 16'd500, 16'd550, 16'd5434, 16'd3};
            1: v = '{16'd5000, 16'd0, 16'd5000, 16'd65535, 16'd65535, 16'd1500, 16'd10000,
                     16'd255};
            2: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, CFG_DATA_W'(-400), 16'd0, 16'd0};
            // Taper start above the target: the limit steps from full to zero.
            3: v = '{16'd4000, 16'd4100, 16'd4300, 16'd20000, 16'd1000, 16'd450, 16'd4000,
                     16'd10};
            // One millivolt taper band.
            4: v = '{16'd4100, 16'd4099, 16'd4150, 16'd65535, 16'd800, 16'd600, 16'd7000, 16'd0};
            5: v = '{default: 16'hFFFF};
            default:
            begin
                target = $urandom_range(3000, 5000);
                v[REG_CELL_TARGET]   = CFG_DATA_W'(target);
                v[REG_TAPER_BEGIN]   = CFG_DATA_W'(target - int'($urandom_range(1, 1500)));
                v[REG_HARD_OVERVOLT] = CFG_DATA_W'(target + int'($urandom_range(0, 200)));
                v[REG_CHARGER_MAX]   = CFG_DATA_W'($urandom);
                v[REG_TERMINATION]   = CFG_DATA_W'($urandom_range(0, 3000));
                v[REG_CUTOFF_TEMP]   = CFG_DATA_W'(-400 + int'($urandom_range(0, 1900)));
                v[REG_PACK_TARGET]   = CFG_DATA_W'($urandom_range(0, 10000));
                v[REG_MAX_SEQ_LAG]   = CFG_DATA_W'($urandom_range(0, 255));
            end
        endcase
        return v;
    endfunction

    // Valid is left high; the caller lowers it after the last write of a setting.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_setting(input reg_set_t v);
        write_reg(REG_CELL_TARGET, v[REG_CELL_TARGET]);
        write_reg(REG_TAPER_BEGIN, v[REG_TAPER_BEGIN]);
        write_reg(REG_HARD_OVERVOLT, v[REG_HARD_OVERVOLT]);
        write_reg(REG_CHARGER_MAX, v[REG_CHARGER_MAX]);
        write_reg(REG_TERMINATION, v[REG_TERMINATION]);
        write_reg(REG_CUTOFF_TEMP, v[REG_CUTOFF_TEMP]);
        write_reg(REG_PACK_TARGET, v[REG_PACK_TARGET]);
        write_reg(REG_MAX_SEQ_LAG, v[REG_MAX_SEQ_LAG]);
        cfg_ch.valid <= 1'b0;
        aim_target = int'(v[REG_CELL_TARGET][MV_W-1:0]);
        aim_taper  = int'(v[REG_TAPER_BEGIN][MV_W-1:0]);
        aim_term   = int'(v[REG_TERMINATION][MA_W-1:0]);
        aim_cut    = int'($signed(v[REG_CUTOFF_TEMP][TEMP_W-1:0]));
        aim_lag    = int'(v[REG_MAX_SEQ_LAG][SEQ_W-1:0]);
    endtask

    task automatic send_status(input cccv_in_t item);
        int gap;
        if ($urandom_range(0, 49) == 0)
            steady_src = !steady_src;
        gap = steady_src ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            status_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        status_ch.valid   <= 1'b1;
        status_ch.payload <= item;
        do @(posedge clk); while (!status_ch.ready);
        sent++;
    endtask

    // The block may still be finishing its output register after the last command.
    task automatic wait_idle();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        command_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                steady_sink = !steady_sink;
            stall = steady_sink ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                command_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            command_ch.ready <= 1'b1;
            do @(posedge clk); while (!command_ch.valid);
            received++;
        end
    end

    initial
    begin
        cccv_in_t s;
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        status_ch.valid   = 1'b0;
        status_ch.payload = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed corner cases under the reset register values.
        s = nominal_status(13'd3900);  send_status(s);
        s = nominal_status(13'd4130);  send_status(s);
        s = nominal_status(13'd4080);  send_status(s);
        s = nominal_status(13'd4179);  send_status(s);
        s = nominal_status(13'd4180);  send_status(s);
        // Termination in CV mode sets the done latch; it holds while plugged in.
        s = nominal_status(13'd4190);  s.measured_current_ma = 16'd100;
        s.charger_mode = MODE_CV;      send_status(s);
        s = nominal_status(13'd3900);  s.plug_status = PLUG_PLUGGED;  send_status(s);
        s = nominal_status(13'd3900);  s.plug_status = PLUG_UNPLUGGED;  send_status(s);
        s = nominal_status(13'd4185);  s.measured_current_ma = 16'd0;  send_status(s);
        s = nominal_status(13'd3900);  s.plug_status = PLUG_OTHER;  send_status(s);
        s = nominal_status(13'd4185);  s.measured_current_ma = 16'd0;
        s.charger_mode = MODE_IDLE;    send_status(s);
        s = nominal_status(13'd4185);  s.measured_current_ma = 16'd0;
        s.charger_mode = MODE_OTHER;   send_status(s);
        s = nominal_status(13'd4201);  send_status(s);
        s = nominal_status(13'd3900);  s.pack_disconnected = 1'b1;  send_status(s);
        s = nominal_status(13'd3900);  s.pack_overtemp = 1'b1;  send_status(s);
        s = nominal_status(13'd3900);  s.shutdown_loop_closed = 1'b0;  send_status(s);
        s = nominal_status(13'd3900);  s.charger_fault_bits = 8'h80;  send_status(s);
        s = nominal_status(13'd4130);  s.max_temp_dc = 12'sd550;  send_status(s);
        s = nominal_status(13'd4130);  s.max_temp_dc = 12'sd549;  send_status(s);
        s = nominal_status(13'd4130);  s.max_temp_dc = 12'h800;  send_status(s);
        s = nominal_status(13'd4130);  s.max_temp_dc = 12'h7FF;  send_status(s);
        s = nominal_status(13'd3900);  s.sequence_echo = s.sequence_echo - 8'd3;  send_status(s);
        s = nominal_status(13'd3900);  s.sequence_echo = s.sequence_echo - 8'd4;  send_status(s);
        s = nominal_status(13'd3900);  s.contactor_charging = 1'b0;  send_status(s);
        s = '1;                        send_status(s);
        status_ch.valid <= 1'b0;

        for (int p = 0; p < SETTINGS_RUN; p++)
        begin
            wait_idle();
            apply_setting(setting_for(p));
            repeat (ITEMS_PER_SETTING) send_status(random_status());
            status_ch.valid <= 1'b0;
        end

        wait_idle();
        $display("Checked %0d commands from %0d status transactions over %0d register settings,",
                 received, sent, SETTINGS_RUN + 1);
        $display("including directed taper, latch, hard stop, thermal and watchdog cases.");
        if (errors == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* cccv_charge_command_controller.f */
rtl/core/cccv_pkg.sv
rtl/core/cccv_if.sv
rtl/core/cccv_taper_div.sv
rtl/core/cccv_charge_command_controller.sv
rtl/core/cccv_checker.sv
verif/cccv_command_checker.sv
verif/tb_top.sv
